[rtl/scsc_pkg.sv]
// ----------------------------------------------------------------------------
// Score seven-segment command package
// Shared types, field widths, command word layout and the digit encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package scsc_pkg;

	// Input and result field widths.
	localparam int unsigned SCORE_W = 16;
	localparam int unsigned SEG_W   = 7;
	localparam int unsigned POS_W   = 2;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned WORD_W  = 29;
	localparam int unsigned NUM_DIGITS = 4;

	// Command word layout.
	localparam logic [2:0] OPC_SCORE_DIGIT = 3'd6;
	localparam int unsigned OPC_LSB = 26;
	localparam int unsigned PLAYER_BIT = 9;

	// Word counter within one run: blank word first, then four digits.
	localparam logic [2:0] IDX_BLANK = 3'd0;
	localparam logic [2:0] IDX_LAST  = 3'd4;

	// Position of the blank word and of the ones digit.
	localparam logic [POS_W-1:0] POS_BLANK = 2'd0;
	localparam logic [POS_W-1:0] POS_ONES  = 2'd3;

	// One run of digits ready for the output sequencer; seg[0] is the ones digit.
	typedef struct packed {
		logic                            player;
		logic [NUM_DIGITS-1:0][SEG_W-1:0] seg;
	} run_t;

	// Common-cathode segment pattern (g..a) of one decimal digit.
	function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[rtl/scsc_bcd_split.sv]
// ----------------------------------------------------------------------------
// Score digit splitter
// Splits a 16-bit score into its four low decimal digits by constant reciprocal
// multiplications and encodes each digit to its segment pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module scsc_bcd_split
	import scsc_pkg::*;
(
	input  wire logic               player,
	input  wire logic [SCORE_W-1:0] score,
	output run_t                    run
);

	// Reciprocals scaled by 2^19, 2^23, 2^26 and 2^30; each is exact for 16-bit scores.
	localparam logic [16:0] RECIP_10    = 17'd52429;
	localparam logic [16:0] RECIP_100   = 17'd83887;
	localparam logic [16:0] RECIP_1000  = 17'd67109;
	localparam logic [16:0] RECIP_10000 = 17'd107375;

	logic [32:0] prod_10;
	logic [32:0] prod_100;
	logic [32:0] prod_1000;
	logic [32:0] prod_10000;
	logic [12:0] q10;
	logic [9:0]  q100;
	logic [6:0]  q1000;
	logic [2:0]  q10000;
	logic [15:0] rem_ones;
	logic [12:0] rem_tens;
	logic [9:0]  rem_hund;
	logic [6:0]  rem_thou;

	// The four quotients are independent of each other.
	assign prod_10    = 33'(score) * 33'(RECIP_10);
	assign prod_100   = 33'(score) * 33'(RECIP_100);
	assign prod_1000  = 33'(score) * 33'(RECIP_1000);
	assign prod_10000 = 33'(score) * 33'(RECIP_10000);

	assign q10    = prod_10[31:19];
	assign q100   = prod_100[32:23];
	assign q1000  = prod_1000[32:26];
	assign q10000 = prod_10000[32:30];

	// Each digit is a quotient less ten times the next one.
	assign rem_ones = score - 16'(q10) * 16'd10;
	assign rem_tens = q10 - 13'(q100) * 13'd10;
	assign rem_hund = q100 - 10'(q1000) * 10'd10;
	assign rem_thou = q1000 - 7'(q10000) * 7'd10;

	// Segment patterns, ones digit first.
	assign run.player = player;
	assign run.seg[0] = seg_encode(rem_ones[DIGIT_W-1:0]);
	assign run.seg[1] = seg_encode(rem_tens[DIGIT_W-1:0]);
	assign run.seg[2] = seg_encode(rem_hund[DIGIT_W-1:0]);
	assign run.seg[3] = seg_encode(rem_thou[DIGIT_W-1:0]);

endmodule

`default_nettype wire

[rtl/scsc_word_seq.sv]
// ----------------------------------------------------------------------------
// Command word sequencer
// Holds one decoded run and sends its blank word and four digit words,
// one per transaction, marking the last with tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module scsc_word_seq
	import scsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire run_t        run,
	output logic             free,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [28:0] command_word, [31:29] zero
	output logic             m_tlast
);

	logic        busy_q;
	logic [2:0]  cnt_q;
	run_t        run_q;
	logic        last;
	logic [1:0]  digit_idx;
	logic [SEG_W-1:0] seg;
	logic [POS_W-1:0] pos;
	logic [WORD_W-1:0] word;

	assign last = (cnt_q == IDX_LAST);

	// A new run may be loaded when idle or as the last word leaves.
	assign free = !busy_q || (m_tready && last);

	// Run control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= IDX_BLANK;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= IDX_BLANK;
		end else if (busy_q && m_tready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	// Run payload.
	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= run;
		end
	end

	// Word assembly: the blank word has no segments and position zero.
	assign digit_idx = 2'(cnt_q - 3'd1);

	always_comb begin
		if (cnt_q == IDX_BLANK) begin
			seg = '0;
			pos = POS_BLANK;
		end else begin
			seg = run_q.seg[digit_idx];
			pos = POS_ONES - digit_idx;
		end
	end

	assign word = {OPC_SCORE_DIGIT, 16'd0, run_q.player, pos, seg};

	assign m_tvalid = busy_q;
	assign m_tdata  = {3'd0, word};
	assign m_tlast  = busy_q && last;

endmodule

`default_nettype wire

[rtl/score_seven_segment_commands_unit.sv]
// ----------------------------------------------------------------------------
// Score seven-segment command unit
// Turns a player number and a binary score into five display command words.
// ----------------------------------------------------------------------------
// An input waits in the input stage until the sequencer is free, then is loaded into it.
// Output moves one word a cycle while m_tready is high; each input yields five words.
// An input is taken while the previous run is still being sent.
// Reset clears the input stage and the sequencer; no payload is reset.
`default_nettype none

module score_seven_segment_commands_unit
	import scsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] score
	input  wire logic        s_tuser,   // [0] player
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [28:0] command_word, [31:29] zero
	output logic             m_tlast
);

	logic               valid_s1;
	logic               player_s1;
	logic [SCORE_W-1:0] score_s1;
	logic               seq_free;
	logic               load;
	run_t               run;

	// The input stage hands its item over when the sequencer can take a run.
	assign load     = valid_s1 && seq_free;
	assign s_tready = !valid_s1 || seq_free;

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			player_s1 <= s_tuser;
			score_s1  <= s_tdata;
		end
	end

	scsc_bcd_split u_split (
		.player (player_s1),
		.score  (score_s1),
		.run    (run)
	);

	scsc_word_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.run      (run),
		.free     (seq_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// An accepted transaction is always held in the input stage next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted input lost before the input stage");

	// A run is not broken off before its last word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("run ended before its last word");

	// A waiting item starts its run right after the previous run ends.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast && valid_s1) |=>
		(m_tvalid && !m_tlast && m_tdata[6:0] == 7'd0))
		else $error("next run did not start with a blank word");

	// Every command word carries the score digit opcode.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[28:26] == OPC_SCORE_DIGIT))
		else $error("command word without the score digit opcode");

endmodule

`default_nettype wire

[dv/tb_score_seven_segment_commands_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Score seven-segment command unit testbench
// Sends player and score transactions into the unit, predicts the five display
// command words of each score, and checks every output transaction in order.
// A short directed table comes first. Random scores follow under several
// patterns of source idling and sink back-pressure.
// ----------------------------------------------------------------------------

module tb_score_seven_segment_commands_unit;
	import scsc_pkg::*;

	// One expected command word with its end-of-run marker.
	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} command_t;

	// One directed score. Rows with typed set carry their segment patterns,
	// with the thousands digit first and the ones digit last.
	typedef struct packed {
		logic                             player;
		logic [SCORE_W-1:0]               score;
		logic                             typed;
		logic [NUM_DIGITS-1:0][SEG_W-1:0] segs;
	} score_row_t;

	localparam int NUM_DIRECTED = 17;
	localparam int ITEMS_PER_PHASE = 73;
	localparam int NUM_PHASES = 4;
	localparam int DRAIN_CYCLES = 20;

	// Segment pattern of each decimal digit, g..a.
	localparam logic [SEG_W-1:0] DIGIT_PATTERN [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	localparam score_row_t DIRECTED_SCORES [NUM_DIRECTED] = '{
		'{1'b0, 16'd0,     1'b1, {7'h3F, 7'h3F, 7'h3F, 7'h3F}},
		'{1'b1, 16'd0,     1'b1, {7'h3F, 7'h3F, 7'h3F, 7'h3F}},
		'{1'b0, 16'd65535, 1'b1, {7'h6D, 7'h6D, 7'h4F, 7'h6D}},
		'{1'b1, 16'd65535, 1'b1, {7'h6D, 7'h6D, 7'h4F, 7'h6D}},
		'{1'b1, 16'd9999,  1'b1, {7'h6F, 7'h6F, 7'h6F, 7'h6F}},
		'{1'b0, 16'd10000, 1'b1, {7'h3F, 7'h3F, 7'h3F, 7'h3F}},
		'{1'b1, 16'd1000,  1'b1, {7'h06, 7'h3F, 7'h3F, 7'h3F}},
		'{1'b0, 16'd1234,  1'b0, '0},
		'{1'b1, 16'd5678,  1'b0, '0},
		'{1'b0, 16'd9012,  1'b0, '0},
		'{1'b1, 16'd1,     1'b0, '0},
		'{1'b0, 16'd10,    1'b0, '0},
		'{1'b1, 16'd100,   1'b0, '0},
		'{1'b0, 16'd19999, 1'b0, '0},
		'{1'b1, 16'h8000,  1'b0, '0},
		'{1'b0, 16'hAAAA,  1'b0, '0},
		'{1'b1, 16'h5555,  1'b0, '0}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [15:0]         s_tdata;   // [15:0] score
	logic                s_tuser;   // [0] player
	logic                m_tvalid;
	logic                m_tready;
	logic [31:0]         m_tdata;   // [28:0] command_word, [31:29] zero
	logic                m_tlast;

	command_t            pending_commands [$];
	int                  error_count = 0;
	int                  source_idle_pct = 0;
	int                  sink_stall_pct = 0;

	score_seven_segment_commands_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Free-running clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard limit on the run time.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// Prints one mismatch and counts it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR %0t: %s got 0x%08h expected 0x%08h", $time, what, got, want);
		error_count++;
	endtask

	// Decimal digits of the score, each taken modulo 10, as segment patterns.
	function automatic logic [NUM_DIGITS-1:0][SEG_W-1:0] score_to_segments(
			input logic [SCORE_W-1:0] score);
		logic [NUM_DIGITS-1:0][SEG_W-1:0] segs;
		int unsigned                      rest;
		rest = score;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			segs[k] = DIGIT_PATTERN[rest % 10];
			rest = rest / 10;
		end
		return segs;
	endfunction

	// Builds one command word from its segments, position and player.
	function automatic logic [31:0] display_word(input logic [SEG_W-1:0] segs,
			input logic [POS_W-1:0] pos, input logic player);
		logic [31:0] w;
		w = '0;
		w[OPC_LSB +: 3] = OPC_SCORE_DIGIT;
		w[PLAYER_BIT] = player;
		w[SEG_W +: POS_W] = pos;
		w[SEG_W-1:0] = segs;
		return w;
	endfunction

	// Queues the blank word and the four digit words of one score display.
	function automatic void queue_display_run(input logic player,
			input logic [NUM_DIGITS-1:0][SEG_W-1:0] segs);
		command_t c;
		c.word = display_word('0, POS_BLANK, player);
		c.last = 1'b0;
		pending_commands.push_back(c);
		for (int k = 0; k < NUM_DIGITS; k++) begin
			c.word = display_word(segs[k], POS_ONES - POS_W'(k), player);
			c.last = (k == NUM_DIGITS - 1);
			pending_commands.push_back(c);
		end
	endfunction

	// Drives one score transaction and queues its commands once accepted.
	task automatic send_score(input logic player, input logic [SCORE_W-1:0] score,
			input logic typed, input logic [NUM_DIGITS-1:0][SEG_W-1:0] typed_segs);
		while ($urandom_range(0, 99) < source_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= score;
		s_tuser <= player;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		queue_display_run(player, typed ? typed_segs : score_to_segments(score));
	endtask

	// Random score, weighted toward digit and wrap boundaries.
	function automatic logic [SCORE_W-1:0] random_score();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return SCORE_W'($urandom);
		else if (pick < 7)
			return SCORE_W'($urandom_range(0, 9999));
		else if (pick == 7)
			return SCORE_W'($urandom_range(9990, 10010));
		else if (pick == 8)
			return SCORE_W'($urandom_range(0, 65) * 1000 + $urandom_range(0, 2));
		else
			return SCORE_W'($urandom_range(60000, 65535));
	endfunction

	// Sink side: random back-pressure and in-order checking of each transaction.
	initial begin
		command_t want;
		logic     ready_now;
		m_tready <= 1'b0;
		forever begin
			ready_now = ($urandom_range(0, 99) >= sink_stall_pct);
			m_tready <= ready_now;
			@(posedge clk);
			if (arst_n && m_tvalid && ready_now) begin
				if (pending_commands.size() == 0) begin
					report_mismatch("unexpected command word", m_tdata, '0);
				end else begin
					want = pending_commands.pop_front();
					if (m_tdata !== want.word)
						report_mismatch("command word", m_tdata, want.word);
					if (m_tlast !== want.last)
						report_mismatch("last marker", 32'(m_tlast), 32'(want.last));
				end
			end
		end
	end

	// Source side: reset, directed table, random phases, then drain and verdict.
	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			send_score(DIRECTED_SCORES[i].player, DIRECTED_SCORES[i].score,
				DIRECTED_SCORES[i].typed, DIRECTED_SCORES[i].segs);

		// Phases: no idling, idle source, stalling sink, both lightly idle.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					source_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					source_idle_pct = 56;
					sink_stall_pct = 0;
				end
				2: begin
					source_idle_pct = 0;
					sink_stall_pct = 56;
				end
				default: begin
					source_idle_pct = 7;
					sink_stall_pct = 7;
				end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_score(1'($urandom_range(0, 1)), random_score(), 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (pending_commands.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/scsc_pkg.sv
rtl/scsc_bcd_split.sv
rtl/scsc_word_seq.sv
rtl/score_seven_segment_commands_unit.sv
dv/tb_score_seven_segment_commands_unit.sv
